[hw/rtl/ccrb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ccrb_pkg;

    // Ring size in bytes; must be a power of two
    localparam int BUFFER_BYTES = 4096;
    localparam int PTR_W        = $clog2(BUFFER_BYTES);
    localparam int LEN_W        = 13;
    localparam int CNT_W        = 13;
    localparam int ACT_W        = 2;

    // Ring size at pointer-plus-one width and last offset at pointer width
    localparam logic [PTR_W:0]   BUF_SIZE = (PTR_W + 1)'(BUFFER_BYTES);
    localparam logic [PTR_W-1:0] BUF_LAST = PTR_W'(BUFFER_BYTES - 1);

    // Action codes
    localparam logic [ACT_W-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TAKE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd2;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [LEN_W-1:0] chunk_length;
    } t_in_item;

    typedef struct packed {
        logic             accepted;
        logic [PTR_W-1:0] region_offset;
        logic [LEN_W-1:0] granted_length;
        logic [CNT_W-1:0] stored_bytes;
    } t_out_item;

endpackage

`default_nettype wire

[hw/rtl/contiguous_chunk_ring_buffer_manager_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake          Payload
// command   in         start, busy        i_cmd    (action, chunk_length)
// result    out        o_done (strobe)    o_result (accepted, region_offset,
//                                                   granted_length, stored_bytes)
//
// Each accepted item passes the input register -> decision -> result register
// path and ends in the o_done strobe; one item is taken every cycle, with the
// pointer registers updated in the same cycle as the result register.
// busy is always low. Reset is synchronous, active low, and leaves the ring empty.
// Each result shows for exactly one cycle; the receiver cannot stall.
module contiguous_chunk_ring_buffer_manager_unit (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire ccrb_pkg::t_in_item i_cmd,
    output logic                    o_done,
    output ccrb_pkg::t_out_item     o_result
);

    logic                r_in_valid;
    ccrb_pkg::t_in_item  r_in;
    logic                r_done;
    ccrb_pkg::t_out_item r_result;
    ccrb_pkg::t_out_item core_result;

    assign busy = 1'b0;

    // Capture the command item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_cmd;
        end
    end

    ccrb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_item   (r_in),
        .o_result (core_result)
    );

    // Register the result item and its strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_result <= core_result;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // Every accepted item yields one strobe through the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result strobe missing after accepted item");

    // A refused item carries no region
    a_refused_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.accepted) |->
        (o_result.region_offset == '0 && o_result.granted_length == '0))
        else $error("refused item carries a region");

    // A flush always grants and empties the ring
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in.action == ccrb_pkg::ACT_FLUSH) |=>
        (o_done && o_result.accepted && o_result.stored_bytes == '0))
        else $error("flush did not empty the ring");

    // No strobe without an item in the input register in the cycle before
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_in_valid) |=> !o_done)
        else $error("spurious result strobe");

endmodule

`default_nettype wire

[hw/rtl/ccrb_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Pointer state and the single-pass grant decision for one item
module ccrb_core (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire ccrb_pkg::t_in_item i_item,
    output ccrb_pkg::t_out_item     o_result
);

    localparam int SUM_W = ccrb_pkg::LEN_W + 1;

    logic [ccrb_pkg::PTR_W-1:0] r_wr, n_wr;
    logic [ccrb_pkg::PTR_W-1:0] r_rd, n_rd;
    logic [ccrb_pkg::PTR_W-1:0] r_mark, n_mark;
    logic [ccrb_pkg::CNT_W-1:0] r_cnt, n_cnt;

    logic [SUM_W-1:0]           len_e;
    logic [SUM_W-1:0]           wr_e;
    logic [SUM_W-1:0]           rd_e;
    logic [SUM_W-1:0]           cnt_e;
    logic [SUM_W-1:0]           room;
    logic [SUM_W-1:0]           rest;
    logic [SUM_W-1:0]           mark_p1;
    logic [SUM_W-1:0]           push_next;
    logic [ccrb_pkg::PTR_W-1:0] push_start;
    logic                       ok;
    logic [ccrb_pkg::PTR_W-1:0] off;
    logic [ccrb_pkg::LEN_W-1:0] glen;

    assign len_e   = SUM_W'(i_item.chunk_length);
    assign wr_e    = SUM_W'(r_wr);
    assign rd_e    = SUM_W'(r_rd);
    assign cnt_e   = SUM_W'(r_cnt);
    assign room    = SUM_W'(ccrb_pkg::BUF_SIZE) - wr_e;
    assign mark_p1 = SUM_W'(r_mark) + SUM_W'(1);
    assign rest    = (mark_p1 > rd_e) ? (mark_p1 - rd_e) : '0;

    // Decide the grant and the next pointers
    always_comb begin
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_mark     = r_mark;
        n_cnt      = r_cnt;
        ok         = 1'b0;
        off        = '0;
        glen       = '0;
        push_start = r_wr;
        push_next  = '0;
        unique case (i_item.action)
            ccrb_pkg::ACT_PUSH: begin
                ok = 1'b1;
                if (len_e >= SUM_W'(ccrb_pkg::BUF_SIZE)) begin
                    ok = 1'b0;
                end else if (r_wr < r_rd && (wr_e + len_e) >= rd_e) begin
                    ok = 1'b0;
                end else if (r_wr > r_rd && room <= len_e) begin
                    if (r_rd == '0) begin
                        ok = 1'b0;
                    end else if (room < len_e) begin
                        if (len_e >= rd_e) begin
                            ok = 1'b0;
                        end else begin
                            // skip the short tail and place at offset zero
                            push_start = '0;
                            n_mark     = r_wr - ccrb_pkg::PTR_W'(1);
                        end
                    end
                end
                push_next = SUM_W'(push_start) + len_e;
                if (ok) begin
                    n_wr = (push_next > SUM_W'(ccrb_pkg::BUF_LAST)) ? '0
                         : push_next[ccrb_pkg::PTR_W-1:0];
                    n_cnt = r_cnt + i_item.chunk_length;
                    off   = push_start;
                    glen  = i_item.chunk_length;
                end else begin
                    n_mark = r_mark;
                end
            end
            ccrb_pkg::ACT_TAKE: begin
                ok = 1'b1;
                if (r_cnt == '0) begin
                    ok = 1'b0;
                end else if (r_rd < r_wr && (rd_e + len_e) >= wr_e) begin
                    ok = 1'b0;
                end else if (r_rd > r_wr && rest == '0) begin
                    ok = 1'b0;
                end else if (r_rd > r_wr && rest <= len_e) begin
                    if (r_wr == '0) begin
                        ok = 1'b0;
                    end else begin
                        // hand out the tail remainder and wrap the reader
                        off    = r_rd;
                        glen   = rest[ccrb_pkg::LEN_W-1:0];
                        n_mark = ccrb_pkg::BUF_LAST;
                        n_rd   = '0;
                        n_cnt  = (cnt_e > rest) ? (r_cnt - rest[ccrb_pkg::CNT_W-1:0]) : '0;
                    end
                end else begin
                    off   = r_rd;
                    glen  = i_item.chunk_length;
                    n_rd  = r_rd + i_item.chunk_length[ccrb_pkg::PTR_W-1:0];
                    n_cnt = (cnt_e > len_e) ? (r_cnt - i_item.chunk_length) : '0;
                end
            end
            ccrb_pkg::ACT_FLUSH: begin
                ok     = 1'b1;
                n_wr   = '0;
                n_rd   = '0;
                n_mark = ccrb_pkg::BUF_LAST;
                n_cnt  = '0;
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign o_result.accepted       = ok;
    assign o_result.region_offset  = off;
    assign o_result.granted_length = glen;
    assign o_result.stored_bytes   = n_cnt;

    // Commit the pointers when an item is in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_mark <= ccrb_pkg::BUF_LAST;
            r_cnt  <= '0;
        end else if (i_valid) begin
            r_wr   <= n_wr;
            r_rd   <= n_rd;
            r_mark <= n_mark;
            r_cnt  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import ccrb_pkg::*;

    // The one action code that the block has no name for
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS  = 500;
    localparam int CALM_ITEMS    = 80;
    localparam int STALL_LIMIT   = 200;
    localparam int DRAIN_CYCLES  = 8;

    // Predict each grant from a private copy of the ring pointers
    class chunk_grant_board;
        logic [PTR_W-1:0] wr_pos;
        logic [PTR_W-1:0] rd_pos;
        logic [PTR_W-1:0] end_mark;
        logic [CNT_W-1:0] held;
        t_out_item        pending_grants[$];
        int unsigned      mismatches;

        function new();
            clear_ring();
            mismatches = 0;
        endfunction

        function void clear_ring();
            wr_pos   = '0;
            rd_pos   = '0;
            end_mark = BUF_LAST;
            held     = '0;
        endfunction

        // Work out the grant that an accepted item should produce
        function void note_command(t_in_item cmd);
            int unsigned w, r, n, mark, cnt, first, nxt, rest, off, len;
            bit          ok, skip, at_tail;
            t_out_item   grant;
            w       = wr_pos;
            r       = rd_pos;
            n       = cmd.chunk_length;
            mark    = end_mark;
            cnt     = held;
            off     = 0;
            len     = 0;
            ok      = 1'b0;
            skip    = 1'b0;
            at_tail = 1'b0;
            case (cmd.action)
                ACT_PUSH: begin
                    ok    = 1'b1;
                    first = w;
                    if (n >= BUFFER_BYTES) begin
                        ok = 1'b0;
                    end else if (w < r && w + n >= r) begin
                        ok = 1'b0;
                    end else if (w > r && BUFFER_BYTES - w <= n) begin
                        // tail too short: skip to offset 0 if the reader allows it
                        if (r == 0) begin
                            ok = 1'b0;
                        end else if (BUFFER_BYTES - w < n) begin
                            if (n >= r) begin
                                ok = 1'b0;
                            end else begin
                                skip  = 1'b1;
                                first = 0;
                            end
                        end
                    end
                    if (ok) begin
                        if (skip) begin
                            mark = w - 1;
                        end
                        nxt = first + n;
                        if (nxt > BUFFER_BYTES - 1) begin
                            nxt = 0;
                        end
                        w   = nxt;
                        cnt = cnt + n;
                        off = first;
                        len = n;
                    end
                end
                ACT_TAKE: begin
                    ok = 1'b1;
                    if (cnt == 0) begin
                        ok = 1'b0;
                    end else if (r < w && r + n >= w) begin
                        ok = 1'b0;
                    end else if (r > w) begin
                        // reader in the tail: grant at most what lies up to and including the end mark
                        rest = (mark + 1 > r) ? mark + 1 - r : 0;
                        if (rest == 0) begin
                            ok = 1'b0;
                        end else if (rest <= n) begin
                            if (w == 0) begin
                                ok = 1'b0;
                            end else begin
                                at_tail = 1'b1;
                                off     = r;
                                len     = rest;
                                mark    = BUFFER_BYTES - 1;
                                r       = 0;
                                cnt     = (cnt > rest) ? cnt - rest : 0;
                            end
                        end
                    end
                    if (ok && !at_tail) begin
                        off = r;
                        len = n;
                        r   = (r + n) % BUFFER_BYTES;
                        cnt = (cnt > n) ? cnt - n : 0;
                    end
                end
                ACT_FLUSH: begin
                    ok   = 1'b1;
                    w    = 0;
                    r    = 0;
                    mark = BUFFER_BYTES - 1;
                    cnt  = 0;
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
            if (!ok) begin
                off = 0;
                len = 0;
            end
            wr_pos   = PTR_W'(w);
            rd_pos   = PTR_W'(r);
            end_mark = PTR_W'(mark);
            held     = CNT_W'(cnt);
            grant.accepted       = ok;
            grant.region_offset  = PTR_W'(off);
            grant.granted_length = LEN_W'(len);
            grant.stored_bytes   = held;
            pending_grants.push_back(grant);
        endfunction

        // Compare one result with the oldest predicted grant
        function void check_result(t_out_item got);
            t_out_item want;
            if (pending_grants.size() == 0) begin
                $error("unexpected result: accepted %0d offset %0d length %0d stored %0d",
                       got.accepted, got.region_offset, got.granted_length,
                       got.stored_bytes);
                mismatches++;
                return;
            end
            want = pending_grants.pop_front();
            if (got.accepted !== want.accepted) begin
                $error("accepted: expected %0d actual %0d", want.accepted, got.accepted);
                mismatches++;
            end
            if (got.region_offset !== want.region_offset) begin
                $error("region_offset: expected %0d actual %0d",
                       want.region_offset, got.region_offset);
                mismatches++;
            end
            if (got.granted_length !== want.granted_length) begin
                $error("granted_length: expected %0d actual %0d",
                       want.granted_length, got.granted_length);
                mismatches++;
            end
            if (got.stored_bytes !== want.stored_bytes) begin
                $error("stored_bytes: expected %0d actual %0d",
                       want.stored_bytes, got.stored_bytes);
                mismatches++;
            end
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_in_item  i_cmd;
    logic      o_done;
    t_out_item o_result;

    chunk_grant_board board;
    int unsigned      quiet_cycles;

    contiguous_chunk_ring_buffer_manager_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Note accepted items and check results at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                board.note_command(i_cmd);
            end
            if (o_done) begin
                board.check_result(o_result);
            end
        end
    end

    // Stop the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("tb_top: FAIL");
                $finish;
            end
        end
    end

    // Present one item from a falling edge and hold it until accepted
    task automatic send_item(input logic [ACT_W-1:0] act, input logic [LEN_W-1:0] len);
        start              <= 1'b1;
        i_cmd.action       <= act;
        i_cmd.chunk_length <= len;
        forever begin
            @(posedge i_clk);
            if (!busy) begin
                break;
            end
        end
        @(negedge i_clk);
    endtask

    // Drop start for a burst of idle cycles
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Pick a length, mostly small so the ring fills and wraps
    function automatic logic [LEN_W-1:0] pick_length();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 40) begin
            return LEN_W'($urandom_range(63));
        end else if (sel < 70) begin
            return LEN_W'($urandom_range(1023, 64));
        end else if (sel < 88) begin
            return LEN_W'($urandom_range(BUFFER_BYTES - 1, 1024));
        end else if (sel < 94) begin
            return LEN_W'($urandom);
        end else begin
            case ($urandom_range(3))
                0:       return '0;
                1:       return LEN_W'(1);
                2:       return LEN_W'(BUFFER_BYTES - 1);
                default: return LEN_W'(BUFFER_BYTES);
            endcase
        end
    endfunction

    function automatic logic [ACT_W-1:0] pick_action();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 48) begin
            return ACT_PUSH;
        end else if (sel < 95) begin
            return ACT_TAKE;
        end else if (sel < 98) begin
            return ACT_FLUSH;
        end else begin
            return ACT_UNUSED;
        end
    endfunction

    initial begin
        bit idle_on;
        board        = new();
        quiet_cycles = 0;
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: refusals, tail skip, take at the tail, flush and the unused code
        send_item(ACT_TAKE, 13'd10);
        send_item(ACT_PUSH, 13'd0);
        send_item(ACT_PUSH, 13'd4096);
        send_item(ACT_PUSH, 13'd8191);
        send_item(ACT_PUSH, 13'd3000);
        send_item(ACT_TAKE, 13'd2000);
        send_item(ACT_PUSH, 13'd1500);
        send_item(ACT_TAKE, 13'd2000);
        send_item(ACT_TAKE, 13'd1500);
        send_item(ACT_TAKE, 13'd1499);
        send_item(ACT_UNUSED, 13'd8191);
        send_item(ACT_PUSH, 13'd3000);
        send_item(ACT_PUSH, 13'd2596);
        send_item(ACT_FLUSH, 13'd0);
        send_item(ACT_PUSH, 13'd4095);
        send_item(ACT_TAKE, 13'd8191);
        send_item(ACT_TAKE, 13'd4094);
        send_item(ACT_PUSH, 13'd1);
        send_item(ACT_TAKE, 13'd5);
        send_item(ACT_PUSH, 13'd100);
        send_item(ACT_TAKE, 13'd5);
        send_item(ACT_TAKE, 13'd0);
        send_item(ACT_FLUSH, 13'd8191);
        send_item(ACT_UNUSED, 13'd0);

        // Random: idling switches on and off in stretches, none near the end
        idle_on = 1'b1;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) begin
                idle_on = $urandom_range(1);
            end
            if (idle_on && i < RANDOM_ITEMS - CALM_ITEMS && $urandom_range(3) == 0) begin
                hold_off($urandom_range(13, 1));
            end
            send_item(pick_action(), pick_length());
        end
        start <= 1'b0;

        // Drain outstanding grants, then allow for the pipeline
        while (board.pending_grants.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.pending_grants.size() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

[contiguous_chunk_ring_buffer_manager_unit.f]
hw/rtl/ccrb_pkg.sv
hw/rtl/ccrb_core.sv
hw/rtl/contiguous_chunk_ring_buffer_manager_unit.sv
dv/tb_top.sv
